### rtl/ray_box_slab_intersection_macros.svh
// assertion macros for the ray versus box slab intersection block
`ifndef RAY_BOX_SLAB_INTERSECTION_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECTION_MACROS_SVH

// same-cycle implication, checked outside reset
`define RBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define RBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rbs_pkg.sv
// shared types and constants for the ray versus box slab intersection block
`default_nettype none
package rbs_pkg;

  localparam int Q_W    = 32;
  localparam int FRAC_W = 16;
  localparam int NUM_W  = Q_W + 1 + FRAC_W;
  localparam int MAG_W  = NUM_W - 1;
  localparam int AXES   = 3;
  localparam int DIV_LAT = Q_W + 3;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [Q_W-1:0] origin_x;
    logic signed [Q_W-1:0] origin_y;
    logic signed [Q_W-1:0] origin_z;
    logic signed [Q_W-1:0] direction_x;
    logic signed [Q_W-1:0] direction_y;
    logic signed [Q_W-1:0] direction_z;
    logic signed [Q_W-1:0] closest_so_far;
  } ray_t;

  typedef struct packed {
    logic                  hit;
    logic signed [Q_W-1:0] new_closest;
  } result_t;

  // per-ray data that rides alongside the dividers
  typedef struct packed {
    logic signed [Q_W-1:0] closest;
    logic [AXES-1:0]       dzero;
    logic [AXES-1:0]       pmiss;
  } side_t;

endpackage
`default_nettype wire

### rtl/rbs_delay.sv
// fixed-depth delay line for side data
`default_nettype none
module rbs_delay #(
  parameter int WIDTH = $bits(rbs_pkg::side_t),
  parameter int DEPTH = rbs_pkg::DIV_LAT
) (
  input  wire logic             clk,
  input  wire logic [WIDTH-1:0] din,
  output logic      [WIDTH-1:0] dout
);
  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    taps[0] <= din;
    for (int i = 1; i < DEPTH; i++) begin
      taps[i] <= taps[i-1];
    end
  end

  assign dout = taps[DEPTH-1];
endmodule
`default_nettype wire

### rtl/rbs_div.sv
// pipelined signed divider, one quotient bit per stage, saturating to 32 bits
`default_nettype none
module rbs_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_vld,
  input  wire logic signed [rbs_pkg::NUM_W-1:0] num,
  input  wire logic signed [rbs_pkg::Q_W-1:0]   den,
  output logic                                  out_vld,
  output logic signed [rbs_pkg::Q_W-1:0]        quot
);
  import rbs_pkg::*;
  `include "ray_box_slab_intersection_macros.svh"

  localparam int WIDE = 2 * Q_W;

  logic             a_vld;
  logic [MAG_W-1:0] a_n;
  logic [Q_W-1:0]   a_d;
  logic             a_neg;

  logic             s_vld [Q_W+1];
  logic [MAG_W-1:0] s_rem [Q_W+1];
  logic [Q_W-1:0]   s_d   [Q_W+1];
  logic             s_neg [Q_W+1];
  logic             s_ovf [Q_W+1];
  logic [Q_W-1:0]   s_q   [Q_W+1];

  logic [MAG_W-1:0] rem_next [Q_W];
  logic [Q_W-1:0]   q_next   [Q_W];

  logic signed [NUM_W-1:0] num_neg;
  logic signed [Q_W-1:0]   den_neg;

  assign num_neg = -num;
  assign den_neg = -den;

  // magnitudes and result sign
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= in_vld;
    end
    a_n   <= num[NUM_W-1] ? num_neg[MAG_W-1:0] : num[MAG_W-1:0];
    a_d   <= den[Q_W-1] ? den_neg : den;
    a_neg <= num[NUM_W-1] ^ den[Q_W-1];
  end

  // quotient needs more than 32 bits when n >= d * 2^32
  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld[0] <= 1'b0;
    end else begin
      s_vld[0] <= a_vld;
    end
    s_rem[0] <= a_n;
    s_d[0]   <= a_d;
    s_neg[0] <= a_neg;
    s_ovf[0] <= {{(WIDE-MAG_W){1'b0}}, a_n} >= {a_d, {Q_W{1'b0}}};
    s_q[0]   <= '0;
  end

  always_comb begin
    logic [WIDE-1:0] shifted;
    logic [WIDE-1:0] wrem;
    logic [WIDE-1:0] diff;
    logic            ge;
    for (int i = 0; i < Q_W; i++) begin
      shifted = {{Q_W{1'b0}}, s_d[i]} << (Q_W - 1 - i);
      wrem    = {{(WIDE-MAG_W){1'b0}}, s_rem[i]};
      diff    = wrem - shifted;
      ge      = wrem >= shifted;
      rem_next[i] = ge ? diff[MAG_W-1:0] : s_rem[i];
      q_next[i]   = s_q[i];
      q_next[i][Q_W-1-i] = ge;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Q_W; i++) begin
      if (rst) begin
        s_vld[i+1] <= 1'b0;
      end else begin
        s_vld[i+1] <= s_vld[i];
      end
      s_rem[i+1] <= rem_next[i];
      s_d[i+1]   <= s_d[i];
      s_neg[i+1] <= s_neg[i];
      s_ovf[i+1] <= s_ovf[i];
      s_q[i+1]   <= q_next[i];
    end
  end

  // sign and saturation
  logic [Q_W-1:0] qm;
  logic           neg_sat;
  assign qm      = s_q[Q_W];
  assign neg_sat = s_ovf[Q_W] || (qm[Q_W-1] && (qm[Q_W-2:0] != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= s_vld[Q_W];
    end
    if (s_neg[Q_W]) begin
      quot <= neg_sat ? Q_MIN : (~qm + 1'b1);
    end else begin
      quot <= (s_ovf[Q_W] || qm[Q_W-1]) ? Q_MAX : qm;
    end
  end

  // history from before the first edge counts as no transfer
  `RBS_ASSERT_NOW(div_latency, 1'b1, out_vld == ($past(in_vld, DIV_LAT) === 1'b1), "divider latency slip")
endmodule
`default_nettype wire

### rtl/rbs_reduce.sv
// slab ordering, near/far reduction and hit decision
`default_nettype none
module rbs_reduce (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_vld,
  input  wire logic signed [rbs_pkg::Q_W-1:0] t_lo [rbs_pkg::AXES],
  input  wire logic signed [rbs_pkg::Q_W-1:0] t_hi [rbs_pkg::AXES],
  input  wire rbs_pkg::side_t                 side,
  output logic                                done,
  output rbs_pkg::result_t                    result
);
  import rbs_pkg::*;
  `include "ray_box_slab_intersection_macros.svh"

  logic                  s1_vld;
  logic signed [Q_W-1:0] s1_enter [AXES];
  logic signed [Q_W-1:0] s1_exit  [AXES];
  logic signed [Q_W-1:0] s1_closest;
  logic                  s1_pmiss;

  logic                  s2_vld;
  logic signed [Q_W-1:0] s2_near;
  logic signed [Q_W-1:0] s2_far;
  logic signed [Q_W-1:0] s2_closest;
  logic                  s2_pmiss;

  // a parallel axis gives the neutral pair
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= in_vld;
    end
    for (int i = 0; i < AXES; i++) begin
      if (side.dzero[i]) begin
        s1_enter[i] <= Q_MIN;
        s1_exit[i]  <= Q_MAX;
      end else if (t_lo[i] < t_hi[i]) begin
        s1_enter[i] <= t_lo[i];
        s1_exit[i]  <= t_hi[i];
      end else begin
        s1_enter[i] <= t_hi[i];
        s1_exit[i]  <= t_lo[i];
      end
    end
    s1_closest <= side.closest;
    s1_pmiss   <= |side.pmiss;
  end

  logic signed [Q_W-1:0] near_c;
  logic signed [Q_W-1:0] far_c;

  always_comb begin
    near_c = s1_enter[0];
    far_c  = s1_exit[0];
    for (int i = 1; i < AXES; i++) begin
      if (s1_enter[i] > near_c) near_c = s1_enter[i];
      if (s1_exit[i] < far_c)   far_c  = s1_exit[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    s2_near    <= near_c;
    s2_far     <= far_c;
    s2_closest <= s1_closest;
    s2_pmiss   <= s1_pmiss;
  end

  logic                  miss;
  logic signed [Q_W-1:0] hit_dist;
  logic                  hit_c;

  assign miss     = s2_pmiss || (s2_near > s2_far) || s2_far[Q_W-1];
  // origin inside the box: distance is the exit
  assign hit_dist = s2_near[Q_W-1] ? s2_far : s2_near;
  assign hit_c    = !miss && (hit_dist <= s2_closest);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_vld;
    end
    result.hit         <= hit_c;
    result.new_closest <= hit_c ? hit_dist : s2_closest;
  end

  `RBS_ASSERT_NOW(hit_not_farther, done && result.hit, result.new_closest <= $past(s2_closest), "hit beyond closest")
  `RBS_ASSERT_NOW(miss_keeps_closest, done && !result.hit, result.new_closest == $past(s2_closest), "miss changed closest")
  `RBS_ASSERT_NEXT(parallel_miss, s2_vld && s2_pmiss, done && !result.hit, "parallel slab miss lost")
endmodule
`default_nettype wire

### rtl/ray_box_slab_intersection.sv
// top level of the ray versus axis-aligned box slab intersection block
//
// A ray is transferred on the rising edge where start is high and busy is low;
// busy is high only during reset, so one ray may enter every cycle.
// The box corners are six signed Q16.16 registers written over the cfg
// channel (cfg_index 0..5 = min x/y/z, max x/y/z); cfg_ready is always high
// outside reset and other indexes are ignored. Write them only while no ray
// is in flight.
// Each ray produces exactly one result, shown on result for one cycle with
// done high, after one input stage, a 35-stage divider (one quotient bit
// per stage, six in parallel for the slab distances), then three stages of
// ordering, near/far reduction and the hit decision. Throughput is one ray
// per cycle.
// The receiver cannot stall; results are not held.
// Reset (synchronous, active high) clears the box to zero and drops every
// ray in flight.
`default_nettype none
module ray_box_slab_intersection (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire rbs_pkg::ray_t                    ray,
  output logic                                  done,
  output rbs_pkg::result_t                      result,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [rbs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rbs_pkg::Q_W-1:0]          cfg_data
);
  import rbs_pkg::*;

  logic signed [Q_W-1:0] box_lo [AXES];
  logic signed [Q_W-1:0] box_hi [AXES];

  assign busy      = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        box_lo[i] <= '0;
        box_hi[i] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_reg_e'(cfg_index))
        REG_MIN_X: box_lo[0] <= cfg_data;
        REG_MIN_Y: box_lo[1] <= cfg_data;
        REG_MIN_Z: box_lo[2] <= cfg_data;
        REG_MAX_X: box_hi[0] <= cfg_data;
        REG_MAX_Y: box_hi[1] <= cfg_data;
        REG_MAX_Z: box_hi[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [Q_W-1:0] org [AXES];
  logic signed [Q_W-1:0] dir [AXES];
  assign org[0] = ray.origin_x;
  assign org[1] = ray.origin_y;
  assign org[2] = ray.origin_z;
  assign dir[0] = ray.direction_x;
  assign dir[1] = ray.direction_y;
  assign dir[2] = ray.direction_z;

  // input stage: scaled numerators and parallel-slab checks
  logic                    s0_vld;
  logic signed [NUM_W-1:0] s0_num_lo [AXES];
  logic signed [NUM_W-1:0] s0_num_hi [AXES];
  logic signed [Q_W-1:0]   s0_dir    [AXES];
  side_t                   s0_side;

  always_ff @(posedge clk) begin
    logic signed [Q_W:0] dlo;
    logic signed [Q_W:0] dhi;
    if (rst) begin
      s0_vld <= 1'b0;
    end else begin
      s0_vld <= start && !busy;
    end
    for (int i = 0; i < AXES; i++) begin
      dlo = {box_lo[i][Q_W-1], box_lo[i]} - {org[i][Q_W-1], org[i]};
      dhi = {box_hi[i][Q_W-1], box_hi[i]} - {org[i][Q_W-1], org[i]};
      s0_num_lo[i]     <= {dlo, {FRAC_W{1'b0}}};
      s0_num_hi[i]     <= {dhi, {FRAC_W{1'b0}}};
      s0_dir[i]        <= dir[i];
      s0_side.dzero[i] <= dir[i] == '0;
      s0_side.pmiss[i] <= (dir[i] == '0) && ((org[i] < box_lo[i]) || (org[i] > box_hi[i]));
    end
    s0_side.closest <= ray.closest_so_far;
  end

  logic [2*AXES-1:0]     div_vld;
  logic signed [Q_W-1:0] t_lo [AXES];
  logic signed [Q_W-1:0] t_hi [AXES];

  for (genvar g = 0; g < AXES; g++) begin : g_axis
    rbs_div u_div_lo (
      .clk     (clk),
      .rst     (rst),
      .in_vld  (s0_vld),
      .num     (s0_num_lo[g]),
      .den     (s0_dir[g]),
      .out_vld (div_vld[2*g]),
      .quot    (t_lo[g])
    );
    rbs_div u_div_hi (
      .clk     (clk),
      .rst     (rst),
      .in_vld  (s0_vld),
      .num     (s0_num_hi[g]),
      .den     (s0_dir[g]),
      .out_vld (div_vld[2*g+1]),
      .quot    (t_hi[g])
    );
  end

  side_t side_d;

  rbs_delay #(
    .WIDTH ($bits(side_t)),
    .DEPTH (DIV_LAT)
  ) u_side (
    .clk  (clk),
    .din  (s0_side),
    .dout (side_d)
  );

  rbs_reduce u_reduce (
    .clk    (clk),
    .rst    (rst),
    .in_vld (&div_vld),
    .t_lo   (t_lo),
    .t_hi   (t_hi),
    .side   (side_d),
    .done   (done),
    .result (result)
  );
endmodule
`default_nettype wire

### tb/testbench.sv
// self-checking testbench for the ray versus axis-aligned box slab intersection block
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import rbs_pkg::*;

  localparam int LATENCY    = 39;
  localparam int CYCLE_CAP  = 400000;
  localparam int N_RANDOM   = 1830;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  ray_t ray;
  logic done;
  result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [Q_W-1:0] cfg_data;

  ray_box_slab_intersection u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .ray(ray),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of the box
  logic signed [Q_W-1:0] box_lo [AXES];
  logic signed [Q_W-1:0] box_hi [AXES];

  ray_t    pending_rays [$];
  result_t expected_hits [$];
  int      idle_pct;
  bit      drain_pause;
  bit      failed;
  int      cycles;

  function automatic longint slab_dist(logic signed [Q_W-1:0] bound,
                                       logic signed [Q_W-1:0] org,
                                       logic signed [Q_W-1:0] dir);
    longint num;
    longint q;
    num = (longint'(bound) - longint'(org)) * 65536;
    q = num / longint'(dir);
    if (q > longint'(Q_MAX)) q = longint'(Q_MAX);
    if (q < longint'(Q_MIN)) q = longint'(Q_MIN);
    return q;
  endfunction

  function automatic result_t predict_hit(ray_t r);
    logic signed [Q_W-1:0] org [AXES];
    logic signed [Q_W-1:0] dir [AXES];
    longint near_t, far_t, ta, tb, hit_dist;
    bit miss;
    result_t res;
    org[0] = r.origin_x; org[1] = r.origin_y; org[2] = r.origin_z;
    dir[0] = r.direction_x; dir[1] = r.direction_y; dir[2] = r.direction_z;
    near_t = longint'(Q_MIN);
    far_t = longint'(Q_MAX);
    miss = 0;
    for (int i = 0; i < AXES; i++) begin
      if (dir[i] == 0) begin
        if (org[i] < box_lo[i] || org[i] > box_hi[i]) miss = 1;
      end else begin
        ta = slab_dist(box_lo[i], org[i], dir[i]);
        tb = slab_dist(box_hi[i], org[i], dir[i]);
        if ((ta < tb ? ta : tb) > near_t) near_t = ta < tb ? ta : tb;
        if ((ta < tb ? tb : ta) < far_t) far_t = ta < tb ? tb : ta;
      end
    end
    if (near_t > far_t || far_t < 0) miss = 1;
    hit_dist = near_t >= 0 ? near_t : far_t;
    res.hit = !miss && hit_dist <= longint'(r.closest_so_far);
    res.new_closest = res.hit ? hit_dist[Q_W-1:0] : r.closest_so_far;
    return res;
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // driver: at each falling edge, offers the ray at the head of the queue unless in reset, paused or idling at random
  always @(negedge clk) begin
    if (rst || pending_rays.size() == 0 || drain_pause ||
        $urandom_range(99) < idle_pct) begin
      start <= 0;
    end else begin
      start <= 1;
      ray <= pending_rays[0];
    end
  end

  // transfer bookkeeping and result checking at the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && start && !busy) begin
      expected_hits.push_back(predict_hit(pending_rays.pop_front()));
    end
    if (!rst && done) begin
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected result hit=%0b new_closest=%h", $time,
                 result.hit, result.new_closest);
        failed <= 1;
      end else begin
        if (result.hit !== expected_hits[0].hit) begin
          $display("%0t: hit expected %0b actual %0b", $time,
                   expected_hits[0].hit, result.hit);
          failed <= 1;
        end
        if (result.new_closest !== expected_hits[0].new_closest) begin
          $display("%0t: new_closest expected %h actual %h", $time,
                   expected_hits[0].new_closest, result.new_closest);
          failed <= 1;
        end
        void'(expected_hits.pop_front());
      end
    end
    if (cycles > CYCLE_CAP) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic logic [Q_W-1:0] rand_q(int sel);
    case (sel)
      0: return Q_MIN;
      1: return Q_MAX;
      2: return '0;
      3: return $urandom_range(65536 * 8) - 65536 * 4;
      default: return $urandom;
    endcase
  endfunction

  // mostly rays through the box neighborhood, some fully random
  function automatic ray_t random_ray();
    ray_t r;
    logic [Q_W-1:0] dir [AXES];
    int mode;
    mode = $urandom_range(9);
    for (int i = 0; i < AXES; i++) begin
      if ($urandom_range(9) == 0) dir[i] = '0;
      else if (mode < 7) dir[i] = $urandom_range(65536 * 4) - 65536 * 2;
      else dir[i] = rand_q($urandom_range(5));
    end
    r.direction_x = dir[0]; r.direction_y = dir[1]; r.direction_z = dir[2];
    if (mode < 7) begin
      r.origin_x = $urandom_range(65536 * 40) - 65536 * 20;
      r.origin_y = $urandom_range(65536 * 40) - 65536 * 20;
      r.origin_z = $urandom_range(65536 * 40) - 65536 * 20;
      r.closest_so_far = $urandom_range(3) == 0 ? rand_q($urandom_range(5))
                                                : $urandom_range(65536 * 60);
    end else begin
      r.origin_x = rand_q($urandom_range(5));
      r.origin_y = rand_q($urandom_range(5));
      r.origin_z = rand_q($urandom_range(5));
      r.closest_so_far = rand_q($urandom_range(5));
    end
    return r;
  endfunction

  task automatic write_box(cfg_reg_e idx, logic [Q_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= REG_MIN_Z) box_lo[idx] = value;
    else box_hi[idx - REG_MAX_X] = value;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic set_box(logic signed [Q_W-1:0] lo, logic signed [Q_W-1:0] hi);
    write_box(REG_MIN_X, lo);
    write_box(REG_MIN_Y, lo);
    write_box(REG_MIN_Z, lo);
    write_box(REG_MAX_X, hi);
    write_box(REG_MAX_Y, hi);
    write_box(REG_MAX_Z, hi);
  endtask

  task automatic wait_drained();
    while (pending_rays.size() != 0 || expected_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic ray_t make_ray(logic [Q_W-1:0] ox, logic [Q_W-1:0] oy,
                                    logic [Q_W-1:0] oz, logic [Q_W-1:0] dx,
                                    logic [Q_W-1:0] dy, logic [Q_W-1:0] dz,
                                    logic [Q_W-1:0] c);
    ray_t r;
    r = {ox, oy, oz, dx, dy, dz, c};
    return r;
  endfunction

  initial begin
    ray_t r;
    rst = 1;
    start = 0;
    ray = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 0;
    drain_pause = 0;
    for (int i = 0; i < AXES; i++) begin
      box_lo[i] = '0;
      box_hi[i] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: two rays against the zero box left by reset
    pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 0, Q_MAX));
    pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 0, 0));
    wait_drained();

    // unit box from -1 to 1
    set_box(-32'sd65536, 32'sd65536);
    pending_rays.push_back(make_ray(-32'sd327680, 0, 0, 32'sd65536, 0, 0, Q_MAX));
    pending_rays.push_back(make_ray(-32'sd327680, 0, 0, 32'sd65536, 0, 0, 32'sd65536));
    pending_rays.push_back(make_ray(0, 0, 0, 32'sd65536, 32'sd65536, 0, Q_MAX));
    pending_rays.push_back(make_ray(32'sd327680, 0, 0, 32'sd65536, 0, 0, Q_MAX));
    pending_rays.push_back(make_ray(0, 32'sd327680, 0, 32'sd65536, 0, 0, Q_MAX));
    pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 0, Q_MAX));
    pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 0, 32'sd100));
    pending_rays.push_back(make_ray(Q_MIN, 0, 0, 32'sd1, 0, 0, Q_MAX));
    pending_rays.push_back(make_ray(Q_MAX, Q_MIN, 0, Q_MIN, Q_MAX, 32'sd1, Q_MAX));
    pending_rays.push_back(make_ray(-32'sd1, -32'sd1, -32'sd1, Q_MAX, Q_MAX, Q_MAX,
                                    Q_MIN));
    pending_rays.push_back(make_ray(-32'sd131072, -32'sd131072, -32'sd131072,
                                    -32'sd1, -32'sd1, -32'sd1, Q_MAX));
    pending_rays.push_back(make_ray(32'hFFFFFFFF, 32'hAAAAAAAA, 32'h55555555,
                                    32'h55555555, 32'hAAAAAAAA, 32'hFFFFFFFF,
                                    32'hFFFFFFFF));
    wait_drained();

    // inverted box: min above max on every axis
    set_box(32'sd65536, -32'sd65536);
    pending_rays.push_back(make_ray(-32'sd327680, 0, 0, 32'sd65536, 32'sd3, 32'sd7, Q_MAX));
    pending_rays.push_back(make_ray(0, 0, 0, 0, 32'sd65536, 32'sd65536, Q_MAX));
    pending_rays.push_back(make_ray(0, 0, 0, 32'sd65536, 32'sd65536, 32'sd65536, Q_MAX));
    wait_drained();

    // extreme box
    set_box(Q_MIN, Q_MAX);
    pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 0, Q_MAX));
    pending_rays.push_back(make_ray(Q_MIN, Q_MAX, 0, 32'sd1, -32'sd1, 32'sd1, Q_MAX));
    pending_rays.push_back(make_ray(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MAX));
    wait_drained();

    // random phases, box changed between them while idle
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_box(-32'sd655360, 32'sd655360);
        1: set_box(Q_MIN, Q_MAX);
        2: begin
          write_box(REG_MIN_X, -32'sd196608);
          write_box(REG_MIN_Y, 32'sd65536);
          write_box(REG_MIN_Z, -32'sd1310720);
          write_box(REG_MAX_X, 32'sd458752);
          write_box(REG_MAX_Y, 32'sd131072);
          write_box(REG_MAX_Z, 32'sd6553600);
        end
        3: begin
          write_box(REG_MIN_X, $urandom);
          write_box(REG_MIN_Y, $urandom);
          write_box(REG_MIN_Z, $urandom);
          write_box(REG_MAX_X, $urandom);
          write_box(REG_MAX_Y, $urandom);
          write_box(REG_MAX_Z, $urandom);
        end
        4: set_box(32'sd65536, -32'sd65536);
        default: set_box(-32'sd1048576, 32'sd1048576);
      endcase
      idle_pct = phase < 2 ? 25 : (phase < 4 ? 47 : 0);
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        r = random_ray();
        pending_rays.push_back(r);
        if (n == 150) begin
          // hold off until the pipe is empty
          while (pending_rays.size() != 0) @(posedge clk);
          drain_pause = 1;
          while (expected_hits.size() != 0) @(posedge clk);
          @(negedge clk);
          drain_pause = 0;
        end
      end
      wait_drained();
    end

    if (!failed) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
